// File: rtl/fit_policy_block_allocator_unit_assert.svh
// assertion macros for the allocator rtl
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FPBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpba check failed");

// next-cycle implication, checked outside reset
`define FPBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpba check failed");

`endif

// File: rtl/fpba_pkg.sv
package fpba_pkg;

    // table geometry
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_WIDTH = 16;
    localparam int TBL_AW     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int SCAN_W     = $clog2(NUM_BLOCKS + 1);

    // item field widths
    localparam int IDX_W   = 4;
    localparam int FSIZE_W = 16;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    // placement rules, the unused code behaves as first fit
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [IDX_W-1:0]   block_index;
        logic [FSIZE_W-1:0] size;
    } t_in_item;

    typedef struct packed {
        logic               granted;
        logic [IDX_W-1:0]   chosen_block;
        logic [FSIZE_W-1:0] space_left;
    } t_out_item;

    typedef struct packed {
        logic                  rd_en;
        logic [TBL_AW-1:0]     rd_addr;
        logic                  wr_en;
        logic [TBL_AW-1:0]     wr_addr;
        logic [SIZE_WIDTH-1:0] wr_data;
    } t_tbl_req;

    // field size to stored width
    function automatic logic [SIZE_WIDTH-1:0] fn_size_in(input logic [FSIZE_W-1:0] v);
        logic [SIZE_WIDTH+FSIZE_W-1:0] ext;
        ext = {{SIZE_WIDTH{1'b0}}, v};
        return ext[SIZE_WIDTH-1:0];
    endfunction

    // stored width to field size
    function automatic logic [FSIZE_W-1:0] fn_size_out(input logic [SIZE_WIDTH-1:0] v);
        logic [SIZE_WIDTH+FSIZE_W-1:0] ext;
        ext = {{FSIZE_W{1'b0}}, v};
        return ext[FSIZE_W-1:0];
    endfunction

    // field index to table address
    function automatic logic [TBL_AW-1:0] fn_idx_to_addr(input logic [IDX_W-1:0] v);
        logic [TBL_AW+IDX_W-1:0] ext;
        ext = {{TBL_AW{1'b0}}, v};
        return ext[TBL_AW-1:0];
    endfunction

    // table address to field index
    function automatic logic [IDX_W-1:0] fn_addr_to_idx(input logic [TBL_AW-1:0] v);
        logic [TBL_AW+IDX_W-1:0] ext;
        ext = {{IDX_W{1'b0}}, v};
        return ext[IDX_W-1:0];
    endfunction

endpackage

// File: rtl/fpba_table.sv
module fpba_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fpba_pkg::t_tbl_req                i_req,
    output logic [fpba_pkg::SIZE_WIDTH-1:0]   o_rd_data
);
    import fpba_pkg::*;

    logic [SIZE_WIDTH-1:0] r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_valid;
    logic [SIZE_WIDTH-1:0] r_rd_data;

    // entries never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_valid[i_req.rd_addr] ? r_mem[i_req.rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/fpba_scan.sv
`include "fit_policy_block_allocator_unit_assert.svh"

module fpba_scan (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  fpba_pkg::t_in_item                  i_in,
    input  logic [1:0]                          i_policy,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]     i_block_count,
    output fpba_pkg::t_tbl_req                  o_tbl_req,
    input  logic [fpba_pkg::SIZE_WIDTH-1:0]     i_rd_data,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output fpba_pkg::t_out_item                 o_res
);
    import fpba_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    t_state                r_state;
    t_in_item              r_item;
    logic [SCAN_W-1:0]     r_ptr;
    logic                  r_dv;
    logic [TBL_AW-1:0]     r_didx;
    logic                  r_found;
    logic [SIZE_WIDTH-1:0] r_best_val;
    logic [TBL_AW-1:0]     r_best_idx;
    t_out_item             r_res;

    logic [SCAN_W-1:0]     w_count;
    logic                  w_issue;
    logic [SIZE_WIDTH-1:0] w_size;
    logic                  w_fits;
    logic                  w_take;
    logic                  w_load_ok;
    logic [SIZE_WIDTH-1:0] w_left;
    t_tbl_req              w_req;
    t_out_item             w_wr_res;

    // blocks scanned, saturated at the table size
    assign w_count = (32'(i_block_count) > 32'(NUM_BLOCKS)) ? SCAN_W'(NUM_BLOCKS)
                                                            : SCAN_W'(i_block_count);

    assign w_size    = fn_size_in(r_item.size);
    assign w_issue   = (r_state == S_SCAN) && (r_ptr < w_count);
    assign w_load_ok = 32'(r_item.block_index) < 32'(NUM_BLOCKS);
    assign w_left    = r_best_val - w_size;

    // candidate compare on the block that just came out of the table
    assign w_fits = i_rd_data >= w_size;
    assign w_take = w_fits && (!r_found
                    || ((i_policy == POL_BEST)  && (i_rd_data < r_best_val))
                    || ((i_policy == POL_WORST) && (i_rd_data > r_best_val)));

    // table access: scan reads, at most one write-back at the end of the item
    always_comb begin
        w_req.rd_en   = w_issue;
        w_req.rd_addr = r_ptr[TBL_AW-1:0];
        w_req.wr_en   = 1'b0;
        w_req.wr_addr = r_best_idx;
        w_req.wr_data = w_left;
        if (r_state == S_WRITE) begin
            if (r_item.mode == MODE_LOAD) begin
                w_req.wr_en   = w_load_ok;
                w_req.wr_addr = fn_idx_to_addr(r_item.block_index);
                w_req.wr_data = w_size;
            end else begin
                w_req.wr_en = 1'b1;
            end
        end
    end

    // result of a load or a granted request
    always_comb begin
        if (r_item.mode == MODE_LOAD) begin
            w_wr_res.granted      = 1'b0;
            w_wr_res.chosen_block = r_item.block_index;
            w_wr_res.space_left   = w_load_ok ? fn_size_out(w_size) : '0;
        end else begin
            w_wr_res.granted      = 1'b1;
            w_wr_res.chosen_block = fn_addr_to_idx(r_best_idx);
            w_wr_res.space_left   = fn_size_out(w_left);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dv    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in;
                        r_ptr   <= '0;
                        r_dv    <= 1'b0;
                        r_found <= 1'b0;
                        r_state <= (i_in.mode == MODE_LOAD) ? S_WRITE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_dv   <= w_issue;
                    r_didx <= r_ptr[TBL_AW-1:0];
                    if (w_issue) begin
                        r_ptr <= r_ptr + SCAN_W'(1);
                    end
                    if (r_dv && w_take) begin
                        r_found    <= 1'b1;
                        r_best_val <= i_rd_data;
                        r_best_idx <= r_didx;
                    end
                    // all reads issued and the last one evaluated
                    if (!w_issue && !r_dv) begin
                        if (r_found) begin
                            r_state <= S_WRITE;
                        end else begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_WRITE: begin
                    r_res   <= w_wr_res;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_tbl_req   = w_req;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    // checks
    `FPBA_ASSERT_NOW(a_no_rw_overlap, i_clk, i_rst_n, w_req.rd_en, !w_req.wr_en)
    `FPBA_ASSERT_NEXT(a_read_gives_data, i_clk, i_rst_n, w_req.rd_en, r_dv)
    `FPBA_ASSERT_NOW(a_grant_in_range, i_clk, i_rst_n, o_res_valid && o_res.granted && r_item.mode == MODE_ALLOC, 32'(r_best_idx) < 32'(w_count))
    `FPBA_ASSERT_NEXT(a_done_frees_input, i_clk, i_rst_n, o_res_valid && i_res_ready, o_in_ready)

endmodule

// File: rtl/fit_policy_block_allocator_unit.sv
// Free-space allocator over a 16-entry table of block sizes, all zero after reset.
// A load item (mode 0) writes one block's free size and returns it; a request item
// (mode 1) scans blocks 0 to block_count-1 under first, best or worst fit, lowest
// index on ties, takes the size from the chosen block and returns grant, index and
// space left, or an all-zero refusal. Items are handled one at a time, paced by the
// single read port of the free-space table, which the scan walks one block per cycle
// (block_count capped at 16) before the write-back. A finished result sits in an
// output register, so the next item is taken while the result still waits.
// Write policy and block_count only while no item is in flight.
module fit_policy_block_allocator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  fpba_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output fpba_pkg::t_out_item                 o_out
);
    import fpba_pkg::*;

    logic [1:0]            r_policy;
    logic [CFG_DATA_W-1:0] r_block_count;
    logic                  r_out_valid;
    t_out_item             r_out;

    t_tbl_req              w_tbl_req;
    logic [SIZE_WIDTH-1:0] w_rd_data;
    logic                  w_res_valid;
    logic                  w_res_ready;
    t_out_item             w_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy      <= POL_FIRST;
            r_block_count <= CFG_DATA_W'(NUM_BLOCKS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POLICY:      r_policy      <= i_cfg_data[1:0];
                CFG_BLOCK_COUNT: r_block_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fpba_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_tbl_req),
        .o_rd_data (w_rd_data)
    );

    fpba_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in          (i_in),
        .i_policy      (r_policy),
        .i_block_count (r_block_count),
        .o_tbl_req     (w_tbl_req),
        .i_rd_data     (w_rd_data),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_res         (w_res)
    );

    // output register, refilled when empty or drained in the same cycle
    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
